FILE: src/mrr_pkg.sv
`timescale 1ns / 1ps

package mrr_pkg;

	localparam logic [15:0] CrcInit      = 16'hFFFF;
	localparam logic [15:0] CrcPoly      = 16'hA001;
	localparam logic [7:0]  ExcFlag      = 8'h80;
	localparam logic [7:0]  MaxByteCount = 8'd250;
	localparam logic [6:0]  FcCountLo    = 7'd1;
	localparam logic [6:0]  FcCountHi    = 7'd4;
	localparam logic [8:0]  ExcLength    = 9'd5;
	localparam logic [8:0]  EchoLength   = 9'd8;
	localparam logic [8:0]  CountExtra   = 9'd5;

	localparam logic REG_UNIT = 1'b0;
	localparam logic REG_FUNC = 1'b1;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_UNIT  = 3'd1,
		ST_FUNC  = 3'd2,
		ST_COUNT = 3'd3,
		ST_CRC   = 3'd4,
		ST_EXC   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		KIND_PENDING   = 4'b0001,
		KIND_EXCEPTION = 4'b0010,
		KIND_COUNT     = 4'b0100,
		KIND_ECHO      = 4'b1000
	} kind_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       frame_done;
		status_t    status;
		logic [7:0] exception_code;
	} res_t;

endpackage

FILE: src/mrr_crc16.sv
`timescale 1ns / 1ps

module mrr_crc16 (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import mrr_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		crc_out = c;
	end

endmodule

FILE: src/mrr_frame.sv
`timescale 1ns / 1ps

module mrr_frame (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       rx_byte,
	input  logic             frame_start,
	input  logic [7:0]       unit,
	input  logic [6:0]       func,
	output mrr_pkg::res_t    res
);
	import mrr_pkg::*;

	logic [15:0] crc_q, crc_e, crc_n, crc_upd;
	logic [8:0]  pos_q, pos_e, pos_n;
	logic [8:0]  len_q, len_e, len_n;
	kind_t       kind_q, kind_e, kind_n;
	logic        recv_q, recv_e, recv_n;
	logic [7:0]  lo_q, lo_e, lo_n;
	logic [7:0]  exc_q, exc_e, exc_n;
	logic [9:0]  pos_p2;
	logic        valid, done;
	status_t     status;

	mrr_crc16 u_crc (
		.crc_in (crc_e),
		.data   (rx_byte),
		.crc_out(crc_upd)
	);

	always_comb begin
		crc_e  = frame_start ? CrcInit      : crc_q;
		pos_e  = frame_start ? 9'd0         : pos_q;
		len_e  = frame_start ? 9'd0         : len_q;
		kind_e = frame_start ? KIND_PENDING : kind_q;
		lo_e   = frame_start ? 8'd0         : lo_q;
		exc_e  = frame_start ? 8'd0         : exc_q;
		recv_e = frame_start | recv_q;
		pos_p2 = {1'b0, pos_e} + 10'd2;

		crc_n  = crc_e;
		len_n  = len_e;
		kind_n = kind_e;
		lo_n   = lo_e;
		exc_n  = exc_e;
		valid  = 1'b0;
		done   = 1'b0;
		status = ST_OK;

		if (recv_e) begin
			priority if (pos_e == 9'd0) begin
				if (rx_byte != unit) begin
					done   = 1'b1;
					status = ST_UNIT;
				end else begin
					crc_n = crc_upd;
				end
			end else if (pos_e == 9'd1) begin
				priority if (rx_byte == ({1'b0, func} | ExcFlag)) begin
					kind_n = KIND_EXCEPTION;
					len_n  = ExcLength;
					crc_n  = crc_upd;
				end else if (rx_byte == {1'b0, func} && func >= FcCountLo
						&& func <= FcCountHi) begin
					kind_n = KIND_COUNT;
					len_n  = 9'd0;
					valid  = 1'b1;
					crc_n  = crc_upd;
				end else if (rx_byte == {1'b0, func}) begin
					kind_n = KIND_ECHO;
					len_n  = EchoLength;
					valid  = 1'b1;
					crc_n  = crc_upd;
				end else begin
					done   = 1'b1;
					status = ST_FUNC;
				end
			end else if (pos_e == 9'd2 && kind_e == KIND_COUNT) begin
				if (rx_byte > MaxByteCount) begin
					done   = 1'b1;
					status = ST_COUNT;
				end else begin
					len_n = {1'b0, rx_byte} + CountExtra;
					crc_n = crc_upd;
					valid = 1'b1;
				end
			end else if (pos_p2 < {1'b0, len_e}) begin
				if (kind_e == KIND_EXCEPTION) begin
					if (pos_e == 9'd2) begin
						exc_n = rx_byte;
					end
				end else begin
					valid = 1'b1;
				end
				crc_n = crc_upd;
			end else if (pos_p2 == {1'b0, len_e}) begin
				lo_n = rx_byte;
			end else begin
				done = 1'b1;
				priority if ({rx_byte, lo_e} != crc_e) begin
					status = ST_CRC;
				end else if (kind_e == KIND_EXCEPTION) begin
					status = ST_EXC;
				end else begin
					status = ST_OK;
				end
			end
		end

		recv_n = recv_e & ~done;
		pos_n  = (recv_e && !done) ? pos_e + 9'd1 : pos_e;

		res.payload_byte   = valid ? rx_byte : 8'd0;
		res.payload_valid  = valid;
		res.frame_done     = done;
		res.status         = status;
		res.exception_code = (done && status == ST_EXC) ? exc_e : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CrcInit;
			pos_q  <= 9'd0;
			len_q  <= 9'd0;
			kind_q <= KIND_PENDING;
			recv_q <= 1'b0;
			lo_q   <= 8'd0;
			exc_q  <= 8'd0;
		end else if (advance) begin
			crc_q  <= crc_n;
			pos_q  <= pos_n;
			len_q  <= len_n;
			kind_q <= kind_n;
			recv_q <= recv_n;
			lo_q   <= lo_n;
			exc_q  <= exc_n;
		end
	end

endmodule

FILE: src/modbus_rtu_response_receiver.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// input     in_valid / in_ready     rx_byte, frame_start
// output    out_valid / out_ready   payload_byte, payload_valid, frame_done, status,
//                                   exception_code
// config    cfg_we                  cfg_index, cfg_data
// One beat per cycle sustained while out_ready is high; each byte passes the input
// register, then the result register, the CRC byte update sitting between them.
// Reset clears frame state and loads expected_function 3, expected_unit 0.
// An output stall holds the result register; the input register refills behind it.

module modbus_rtu_response_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic       frame_done,
	output logic [2:0] status,
	output logic [7:0] exception_code,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import mrr_pkg::*;

	logic [7:0] unit_q;
	logic [6:0] func_q;
	logic       v_s1, v_s2;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       advance;
	res_t       res, res_s2;

	assign advance  = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= 8'd0;
			func_q <= 7'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UNIT: unit_q <= cfg_data;
				REG_FUNC: func_q <= cfg_data[6:0];
				default:  unit_q <= unit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	mrr_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.rx_byte    (byte_s1),
		.frame_start(start_s1),
		.unit       (unit_q),
		.func       (func_q),
		.res        (res)
	);

	assign out_valid      = v_s2;
	assign payload_byte   = res_s2.payload_byte;
	assign payload_valid  = res_s2.payload_valid;
	assign frame_done     = res_s2.frame_done;
	assign status         = res_s2.status;
	assign exception_code = res_s2.exception_code;

endmodule

FILE: src/mrr_checker.sv
`timescale 1ns / 1ps

module mrr_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] payload_byte,
	input  logic       payload_valid,
	input  logic       frame_done,
	input  logic [2:0] status,
	input  logic [7:0] exception_code
);
	import mrr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(status) && $stable(frame_done))
		else $error("output beat changed while stalled");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> frame_done)
		else $error("status reported without frame end");

	a_exc_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exception_code != 8'd0 |-> frame_done && status == ST_EXC)
		else $error("exception code outside exception status");

	a_done_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !payload_valid)
		else $error("payload on final beat");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("payload byte not cleared");

endmodule

bind modbus_rtu_response_receiver mrr_checker u_mrr_checker (.*);
